// ===== rtl/pwrt_pkg.sv =====
`timescale 1ns / 1ps
package pwrt_pkg;

  localparam logic [1:0] ACT_CHECK   = 2'd0;
  localparam logic [1:0] ACT_ENABLE  = 2'd1;
  localparam logic [1:0] ACT_DISABLE = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_KIND = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef logic [1:0] scan_op_t;

  localparam scan_op_t OP_LOOKUP = 2'd0;
  localparam scan_op_t OP_INSERT = 2'd1;
  localparam scan_op_t OP_REMOVE = 2'd2;

  typedef struct packed {
    logic     start;
    scan_op_t op;
  } scan_req_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic hit;
    logic full;
    logic empty;
  } scan_rsp_t;

endpackage

// ===== rtl/pwrt_scan.sv =====
`timescale 1ns / 1ps
module pwrt_scan #(
  parameter int TABLE_ENTRIES = 64,
  parameter int PAGE_W        = 36,
  parameter int COUNT_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  pwrt_pkg::scan_req_t req,
  input  logic [PAGE_W-1:0]   page,
  output pwrt_pkg::scan_rsp_t rsp
);
  import pwrt_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int WW = 1 + PAGE_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [WW-1:0]         mem [TABLE_ENTRIES];
  logic [WW-1:0]         rd_data;
  logic [1:0]            state;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         occ;
  logic                  rd_pend;
  logic [IW-1:0]         rd_idx;
  logic                  hit;
  logic [IW-1:0]         hit_idx;
  logic [COUNT_BITS-1:0] hit_rc;
  logic                  free_found;
  logic [IW-1:0]         free_idx;
  scan_op_t              op;
  logic [PAGE_W-1:0]     pg;

  logic                  re;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [WW-1:0]         wdata;
  logic                  rd_valid;
  logic [PAGE_W-1:0]     rd_page;
  logic [COUNT_BITS-1:0] rd_rc;

  assign re       = (state == S_SCAN) && (cnt < CW'(TABLE_ENTRIES));
  assign rd_valid = rd_data[WW-1];
  assign rd_page  = rd_data[WW-2:COUNT_BITS];
  assign rd_rc    = rd_data[COUNT_BITS-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = hit ? hit_idx : free_idx;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt[IW-1:0];
      end
      S_WRITE: begin
        case (op)
          OP_INSERT: begin
            we = hit || free_found;
            if (hit) begin
              wdata = {1'b1, pg, (hit_rc == COUNT_MAX) ? hit_rc : hit_rc + 1'b1};
            end else begin
              wdata = {1'b1, pg, COUNT_BITS'(1)};
            end
          end
          OP_REMOVE: begin
            we = hit;
            if (hit_rc < COUNT_BITS'(2)) begin
              wdata = {1'b0, pg, hit_rc};
            end else begin
              wdata = {1'b1, pg, hit_rc - 1'b1};
            end
          end
          default: we = 1'b0;
        endcase
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[cnt[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      occ     <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt[IW-1:0] == IW'(TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.start) begin
            op         <= req.op;
            pg         <= page;
            cnt        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            rd_pend    <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= re;
          rd_idx  <= cnt[IW-1:0];
          if (re) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_pend) begin
            if (rd_valid && rd_page == pg) begin
              hit     <= 1'b1;
              hit_idx <= rd_idx;
              hit_rc  <= rd_rc;
            end
            // keep the lowest free index
            if (!rd_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rd_idx == IW'(TABLE_ENTRIES - 1)) begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (op == OP_INSERT && !hit && free_found) begin
            occ <= occ + 1'b1;
          end else if (op == OP_REMOVE && hit && hit_rc < COUNT_BITS'(2)) begin
            occ <= occ - 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.ready = (state == S_IDLE);
  assign rsp.done  = (state == S_WRITE);
  assign rsp.hit   = hit;
  assign rsp.full  = !hit && !free_found;
  assign rsp.empty = (occ == '0);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(TABLE_ENTRIES))
    else $error("occupancy above table size");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start && state == S_IDLE |=> state == S_SCAN)
    else $error("scan did not start");

  a_write_after_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> $past(state) == S_SCAN)
    else $error("write without a full scan");

endmodule

// ===== rtl/page_watch_refcount_table_unit.sv =====
`timescale 1ns / 1ps
// channel | signals                                          | direction
// --------+--------------------------------------------------+----------
// input   | in_valid, in_stall, action .. page_count         | in
// output  | out_valid, out_stall, stop_needed .. unmap_request | out
//
// A check settled by the whole-memory counters, a whole-memory update or an item
// that touches no page goes straight to the result register; a table lookup waits
// for one entry-by-entry scan of the table memory, and a range for one such scan
// per page, an enable stopping early at the first page with no room.
// The input can take the next item in the cycle after the result register is loaded.
// After reset the table is cleared entry by entry with in_stall high.
// The result register holds a transfer under out_stall; the next item is taken
// meanwhile and waits in its final state until the register frees.
module page_watch_refcount_table_unit #(
  parameter int TABLE_ENTRIES = 64,
  parameter int PAGE_BITS     = 12,
  parameter int ADDRESS_BITS  = 48,
  parameter int COUNT_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [ADDRESS_BITS-1:0]           fault_address,
  input  logic                              is_read,
  input  logic                              is_write,
  input  logic                              is_fetch,
  input  logic                              whole_memory,
  input  logic [2:0]                        access_kinds,
  input  logic [ADDRESS_BITS-PAGE_BITS-1:0] first_page,
  input  logic [7:0]                        page_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              stop_needed,
  output logic [1:0]                        status,
  output logic                              watching_active,
  output logic                              unmap_request
);
  import pwrt_pkg::*;

  localparam int PAGE_W = ADDRESS_BITS - PAGE_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_ISSUE = 2'd1;
  localparam logic [1:0] T_WAIT  = 2'd2;
  localparam logic [1:0] T_DONE  = 2'd3;

  logic [1:0]            state;
  logic [1:0]            act;
  logic [PAGE_W-1:0]     cursor;
  logic [7:0]            remaining;
  logic                  res_stop;
  logic [1:0]            res_status;
  logic                  touched;
  logic                  active_flag;
  logic [COUNT_BITS-1:0] g_read;
  logic [COUNT_BITS-1:0] g_write;
  logic [COUNT_BITS-1:0] g_exec;

  scan_req_t             req;
  scan_rsp_t             rsp;
  logic                  accept;
  logic                  global_stop;
  logic                  out_free;
  logic                  active_next;

  pwrt_scan #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PAGE_W       (PAGE_W),
    .COUNT_BITS   (COUNT_BITS)
  ) u_scan (
    .clk (clk),
    .rst (rst),
    .req (req),
    .page(cursor),
    .rsp (rsp)
  );

  assign in_stall    = (state != T_IDLE) || !rsp.ready;
  assign accept      = in_valid && !in_stall;
  assign global_stop = (is_read && g_read != '0) || (is_write && g_write != '0) ||
                       (is_fetch && g_exec != '0);
  assign out_free    = !out_valid || !out_stall;

  assign req.start = (state == T_ISSUE) && rsp.ready;
  assign req.op    = (act == ACT_CHECK) ? OP_LOOKUP :
                     (act == ACT_ENABLE) ? OP_INSERT : OP_REMOVE;

  always_comb begin
    active_next = active_flag;
    if (act == ACT_ENABLE && touched) begin
      active_next = 1'b1;
    end else if (act == ACT_DISABLE && res_status != STATUS_NO_KIND && g_read == '0 &&
                 g_write == '0 && g_exec == '0 && rsp.empty) begin
      active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      out_valid   <= 1'b0;
      active_flag <= 1'b0;
      g_read      <= '0;
      g_write     <= '0;
      g_exec      <= '0;
    end else begin
      if (out_valid && !out_stall && state != T_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            act       <= action;
            remaining <= page_count;
            case (action)
              ACT_CHECK: begin
                cursor     <= fault_address[ADDRESS_BITS-1:PAGE_BITS];
                res_stop   <= global_stop;
                res_status <= STATUS_OK;
                touched    <= 1'b0;
                state      <= global_stop ? T_DONE : T_ISSUE;
              end
              ACT_ENABLE, ACT_DISABLE: begin
                cursor     <= first_page;
                res_stop   <= 1'b0;
                res_status <= (access_kinds == 3'b000) ? STATUS_NO_KIND : STATUS_OK;
                touched    <= (access_kinds != 3'b000) && whole_memory &&
                              (action == ACT_ENABLE);
                state      <= (access_kinds != 3'b000 && !whole_memory &&
                               page_count != 8'd0) ? T_ISSUE : T_DONE;
                if (access_kinds != 3'b000 && whole_memory) begin
                  if (action == ACT_ENABLE) begin
                    if (access_kinds[0] && g_read != COUNT_MAX) g_read <= g_read + 1'b1;
                    if (access_kinds[1] && g_write != COUNT_MAX) g_write <= g_write + 1'b1;
                    if (access_kinds[2] && g_exec != COUNT_MAX) g_exec <= g_exec + 1'b1;
                  end else begin
                    if (access_kinds[0] && g_read != '0) g_read <= g_read - 1'b1;
                    if (access_kinds[1] && g_write != '0) g_write <= g_write - 1'b1;
                    if (access_kinds[2] && g_exec != '0) g_exec <= g_exec - 1'b1;
                  end
                end
              end
              default: begin
                cursor     <= first_page;
                res_stop   <= 1'b0;
                res_status <= STATUS_OK;
                touched    <= 1'b0;
                state      <= T_DONE;
              end
            endcase
          end
        end
        T_ISSUE: begin
          if (rsp.ready) begin
            state <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (rsp.done) begin
            if (act == ACT_CHECK) begin
              res_stop <= rsp.hit;
              state    <= T_DONE;
            end else if (act == ACT_ENABLE && rsp.full) begin
              // stop at the first page with no room
              res_status <= STATUS_FULL;
              state      <= T_DONE;
            end else begin
              if (act == ACT_ENABLE) begin
                touched <= 1'b1;
              end
              cursor    <= cursor + 1'b1;
              remaining <= remaining - 1'b1;
              state     <= (remaining == 8'd1) ? T_DONE : T_ISSUE;
            end
          end
        end
        T_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            stop_needed     <= res_stop;
            status          <= res_status;
            watching_active <= active_next;
            unmap_request   <= active_next && !active_flag;
            active_flag     <= active_next;
            state           <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_unmap_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && unmap_request |-> watching_active)
    else $error("unmap without active watching");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != T_IDLE)
    else $error("accepted item dropped");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == T_WAIT)
    else $error("scan result with nobody waiting");

  a_full_no_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> !stop_needed && !unmap_request || watching_active)
    else $error("full status with inconsistent result");

endmodule
